// ===== sv/cbf_pkg.sv =====
`timescale 1ns / 1ps

package cbf_pkg;

	localparam int UNIT_W = 34;
	localparam int CNT_W  = 6;

	localparam logic OP_PARAM  = 1'b0;
	localparam logic OP_WEIGHT = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQRT,
		S_MUL,
		S_DIV,
		S_ACC,
		S_DONE
	} cbf_state_t;

	typedef struct packed {
		logic        opcode;
		logic [31:0] bn_scale;
		logic [31:0] bn_mean;
		logic [30:0] bn_variance;
		logic [31:0] filter_bias;
		logic [31:0] weight_value;
	} cbf_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] result_value;
		logic        saturated;
	} cbf_res_t;

	typedef struct packed {
		logic ge;
		logic [UNIT_W-1:0] diff;
	} cbf_cs_t;

endpackage

// ===== sv/conv_batchnorm_fold_top.sv =====
`timescale 1ns / 1ps

// channel | dir | handshake                  | payload
// s       | in  | s_tvalid / s_tready        | s_tuser: opcode; s_tdata: see port
// m       | out | m_tvalid / m_tready        | m_tuser: kind, saturated; m_tdata: value
// cfg     | in  | cfg_valid / cfg_ready      | cfg_data: fold_enable
//
// Parameter word: ceil((31+FRAC_BITS)/2) root steps, a multiply, 64 divide steps,
// one subtract and the result; a weight word skips the root steps and subtract.
// Unfolded: no multiply or divide. Root and divide steps share one compare-subtract.
// Reset: fold_enable 1, denominator 1 LSB, scale 0. No clearing pass.
// A finished result sits in the output register; the next word is taken meanwhile.
module conv_batchnorm_fold_top
	import cbf_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] bn_scale, [63:32] bn_mean, [94:64] bn_variance,
	// [126:95] filter_bias, [158:127] weight_value, [159] zero
	input  logic [159:0] s_tdata,
	// [0] opcode
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] result_value
	output logic [31:0]  m_tdata,
	// [0] result_kind, [1] saturated
	output logic [1:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data
);

	logic      fold_q;
	logic      m_valid_q;
	cbf_res_t  out_q;
	cbf_item_t item;
	cbf_res_t  res;
	logic      res_valid;
	logic      res_take;
	logic      seq_ready;

	assign item.opcode       = s_tuser;
	assign item.bn_scale     = s_tdata[31:0];
	assign item.bn_mean      = s_tdata[63:32];
	assign item.bn_variance  = s_tdata[94:64];
	assign item.filter_bias  = s_tdata[126:95];
	assign item.weight_value = s_tdata[158:127];

	assign cfg_ready = 1'b1;
	assign s_tready  = seq_ready;
	assign res_take  = res_valid && (!m_valid_q || m_tready);

	cbf_seq #(
		.FRAC_BITS(FRAC_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.fold_enable(fold_q),
		.item_valid (s_tvalid),
		.item       (item),
		.ready      (seq_ready),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q    <= 1'b1;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				fold_q <= cfg_data;
			if (res_take)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take)
			out_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q.result_value;
	assign m_tuser  = {out_q.saturated, out_q.result_kind};

endmodule

// ===== sv/cbf_csub.sv =====
`timescale 1ns / 1ps

// shared compare-subtract step, used by both the root and the divide recurrence
module cbf_csub
	import cbf_pkg::*;
(
	input  logic [UNIT_W-1:0] rem,
	input  logic [UNIT_W-1:0] trial,
	output cbf_cs_t           res
);

	logic [UNIT_W:0] sub;

	assign sub      = {1'b0, rem} - {1'b0, trial};
	assign res.ge   = ~sub[UNIT_W];
	assign res.diff = sub[UNIT_W-1:0];

endmodule

// ===== sv/cbf_seq.sv =====
`timescale 1ns / 1ps

module cbf_seq
	import cbf_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fold_enable,
	input  logic      item_valid,
	input  cbf_item_t item,
	output logic      ready,
	output logic      res_valid,
	input  logic      res_take,
	output cbf_res_t  res
);

	localparam int SQ_STEPS = (31 + FRAC_BITS + 1) / 2;
	localparam int SQ_W     = 2 * SQ_STEPS;
	localparam int SQ_SH    = 64 - SQ_W + FRAC_BITS;

	cbf_state_t state_q, state_d;

	logic              op_q;
	logic              neg_q;
	logic [31:0]       a_q, b_q;
	logic signed [31:0] bias_q;
	logic [UNIT_W-1:0] r_q;
	logic [63:0]       q_q;
	logic [63:0]       n_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       den_q;
	logic [31:0]       scale_q;
	logic signed [63:0] val_q;

	logic              accept;
	logic              last_step;
	logic [UNIT_W-1:0] unit_rem, unit_trial;
	cbf_cs_t           cs;
	logic [31:0]       abs_w, abs_sc, abs_st, abs_mean;
	logic [31:0]       root_next;
	logic signed [63:0] q_signed;

	assign accept    = item_valid && ready;
	assign last_step = (cnt_q == '0);

	assign unit_rem   = (state_q == S_SQRT) ? {r_q[31:0], n_q[63:62]} : {r_q[32:0], n_q[63]};
	assign unit_trial = (state_q == S_SQRT) ? {q_q[31:0], 2'b01} : {2'b00, den_q};

	cbf_csub u_csub (
		.rem  (unit_rem),
		.trial(unit_trial),
		.res  (cs)
	);

	assign abs_w     = item.weight_value[31] ? -item.weight_value : item.weight_value;
	assign abs_sc    = item.bn_scale[31] ? -item.bn_scale : item.bn_scale;
	assign abs_st    = scale_q[31] ? -scale_q : scale_q;
	assign abs_mean  = item.bn_mean[31] ? -item.bn_mean : item.bn_mean;
	// root including the bit decided in this last step, plus one LSB
	assign root_next = {q_q[30:0], cs.ge} + 32'd1;
	assign q_signed  = neg_q ? -$signed(q_q) : $signed(q_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item.opcode == OP_PARAM)
						state_d = S_SQRT;
					else if (fold_enable)
						state_d = S_MUL;
					else
						state_d = S_DONE;
				end
			end
			S_SQRT: begin
				if (last_step)
					state_d = fold_enable ? S_MUL : S_DONE;
			end
			S_MUL: state_d = S_DIV;
			S_DIV: begin
				if (last_step)
					state_d = S_ACC;
			end
			S_ACC: state_d = S_DONE;
			S_DONE: begin
				if (res_take)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ready            = 1'b0;
		res_valid        = 1'b0;
		res.result_kind  = op_q;
		res.result_value = val_q[31:0];
		res.saturated    = 1'b0;
		unique case (state_q)
			S_IDLE: ready = 1'b1;
			S_DONE: begin
				res_valid = 1'b1;
				if (val_q > 64'sd2147483647) begin
					res.result_value = 32'h7FFF_FFFF;
					res.saturated    = 1'b1;
				end else if (val_q < -64'sd2147483648) begin
					res.result_value = 32'h8000_0000;
					res.saturated    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			den_q   <= 32'd1;
			scale_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && item.opcode == OP_PARAM)
				scale_q <= item.bn_scale;
			if (state_q == S_SQRT && last_step)
				den_q <= root_next;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q   <= item.opcode;
					bias_q <= item.filter_bias;
					r_q    <= '0;
					q_q    <= '0;
					if (item.opcode == OP_PARAM) begin
						n_q   <= 64'(item.bn_variance) << SQ_SH;
						cnt_q <= CNT_W'(SQ_STEPS - 1);
						a_q   <= abs_sc;
						b_q   <= abs_mean;
						neg_q <= item.bn_scale[31] ^ item.bn_mean[31];
						val_q <= 64'(signed'(item.filter_bias));
					end else begin
						a_q   <= abs_w;
						b_q   <= abs_st;
						neg_q <= item.weight_value[31] ^ scale_q[31];
						val_q <= 64'(signed'(item.weight_value));
					end
				end
			end
			S_SQRT: begin
				r_q   <= cs.ge ? cs.diff : unit_rem;
				q_q   <= {q_q[62:0], cs.ge};
				n_q   <= {n_q[61:0], 2'b00};
				cnt_q <= cnt_q - 1'b1;
			end
			S_MUL: begin
				n_q   <= 64'(a_q) * 64'(b_q);
				r_q   <= '0;
				q_q   <= '0;
				cnt_q <= '1;
			end
			S_DIV: begin
				r_q   <= cs.ge ? cs.diff : unit_rem;
				q_q   <= {q_q[62:0], cs.ge};
				n_q   <= {n_q[62:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			S_ACC: begin
				if (op_q == OP_WEIGHT)
					val_q <= q_signed;
				else
					val_q <= 64'(bias_q) - q_signed;
			end
			default: ;
		endcase
	end

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		den_q != '0)
		else $error("denominator reached zero");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> r_q < {2'b00, den_q})
		else $error("divide remainder not below denominator");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after result taken");

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_take |=> res_valid && $stable(val_q))
		else $error("pending result dropped or changed");

endmodule
